// ----- rtl/eht_pkg.sv -----
// Package: constants, types and register indexes for the elevation histogram tilt finder.
package eht_pkg;

    localparam int NUM_BINS  = 1024;
    localparam int MAX_TILTS = 32;
    localparam int MAX_PEAKS = 256;
    localparam int BIN_W     = $clog2(NUM_BINS);
    localparam int PEAK_W    = $clog2(MAX_PEAKS);
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BIN_WIDTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_BIN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BINS_IN_USE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SEARCH_W    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_BEAMS   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_FRAC    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CHECK_MODE  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_BPC         = 3'd7;

    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_COMPUTE = 1'b1;
    localparam logic KIND_TILT    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef struct packed {
        logic        op;
        logic [14:0] elevation;
    } t_in_item;

    typedef struct packed {
        logic        kind;
        logic [17:0] tilt_elevation;
        logic [15:0] tilt_beams;
        logic [5:0]  tilt_count;
        logic [15:0] beams_used;
        logic        last;
    } t_out_item;

    // Divider request and reply between the top level and the divider
    typedef struct packed {
        logic        start;
        logic [21:0] num;
        logic [10:0] den;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [21:0] quo;
    } t_div_rsp;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_DIV,
        ST_INC_RD,
        ST_INC_WR,
        ST_SCAN_SET,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_SUM_RD,
        ST_SUM_ACC,
        ST_SUM_END,
        ST_FILT_RD,
        ST_FILT_MUL,
        ST_FILT_CHK,
        ST_ELEV_MUL,
        ST_SUMMARY
    } t_state;

endpackage

// ----- rtl/eht_stream_if.sv -----
// Interface: valid/ready channel carrying one item.
interface eht_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/eht_divider.sv -----
// Module: restoring serial divider, one quotient bit per cycle.
module eht_divider
    import eht_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);
    logic [21:0] r_quo, n_quo;
    logic [11:0] r_rem, n_rem;
    logic [10:0] r_den;
    logic [4:0]  r_cnt;
    logic        r_busy, r_done;
    logic [11:0] w_trial;

    always_comb begin
        w_trial = {r_rem[10:0], r_quo[21]};
        n_quo   = {r_quo[20:0], 1'b0};
        n_rem   = w_trial;
        if (w_trial >= {1'b0, r_den}) begin
            n_rem    = w_trial - {1'b0, r_den};
            n_quo[0] = 1'b1;
        end
    end

    // Shift one numerator bit a cycle into the remainder
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'd22;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.num;
            r_rem <= '0;
            r_den <= i_req.den;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;

    a_done_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done) else $error("divider done held two cycles");
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_busy) else $error("divider started while busy");
    a_busy_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_cnt != 5'd0) else $error("divider count lost");
endmodule

// ----- rtl/elevation_histogram_tilt_finder_core.sv -----
// Top level: elevation histogram with serial binning, peak scan and tilt filter.
//
//  channel   dir  handshake        payload
//  in_ch     in   valid/ready      op, elevation
//  out_ch    out  valid/ready      kind, tilt_elevation, tilt_beams, tilt_count,
//                                  beams_used, last
//  cfg       in   i_cfg_we         i_cfg_index, i_cfg_data
//
// A load item starts the serial divider, waits for its 22-bit quotient and its done
// pulse, then reads and writes the histogram memory before the next accept. A compute
// item walks the histogram through its one read port: it scans the window of each bin,
// sums the window of each kept peak, then filters the stored peaks and sends the
// accepted tilts and a summary, then clears the memory. After reset a clearing pass
// runs before the first item. The input is not ready while an item is at work; a
// result waits while the one before it is held, and goes out only after that one is
// taken.
module elevation_histogram_tilt_finder_core
    import eht_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    eht_stream_if.sink           in_ch,
    eht_stream_if.source         out_ch,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);
    // Configuration registers
    logic [9:0]  r_bin_width, r_zero_bin;
    logic [10:0] r_bins;
    logic [3:0]  r_sw;
    logic [15:0] r_min_beams;
    logic [8:0]  r_min_frac;
    logic [1:0]  r_check;
    logic [12:0] r_bpc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bin_width <= 10'd10;
            r_zero_bin  <= 10'd100;
            r_bins      <= 11'd1024;
            r_sw        <= 4'd3;
            r_min_beams <= '0;
            r_min_frac  <= '0;
            r_check     <= '0;
            r_bpc       <= 13'd360;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_BIN_WIDTH:   r_bin_width <= i_cfg_data[9:0];
                REG_ZERO_BIN:    r_zero_bin  <= i_cfg_data[9:0];
                REG_BINS_IN_USE: r_bins      <= i_cfg_data[10:0];
                REG_SEARCH_W:    r_sw        <= i_cfg_data[3:0];
                REG_MIN_BEAMS:   r_min_beams <= i_cfg_data[15:0];
                REG_MIN_FRAC:    r_min_frac  <= i_cfg_data[8:0];
                REG_CHECK_MODE:  r_check     <= i_cfg_data[1:0];
                REG_BPC:         r_bpc       <= i_cfg_data[12:0];
                default:         ;
            endcase
        end
    end

    // Effective settings
    logic [9:0]  w_bw;
    logic [10:0] w_nb;
    logic [3:0]  w_w;
    assign w_bw = (r_bin_width == '0) ? 10'd1 : r_bin_width;
    assign w_nb = (r_bins == '0) ? 11'd1 :
                  (r_bins > 11'(NUM_BINS)) ? 11'(NUM_BINS) : r_bins;
    assign w_w  = (r_sw == '0) ? 4'd1 : r_sw;

    // Histogram memory, one port with registered read
    logic [15:0] r_hist [NUM_BINS];
    logic [15:0] r_hrd;
    logic [BIN_W-1:0] w_haddr;
    logic        w_hwe;
    logic [15:0] w_hwd;
    always_ff @(posedge i_clk) begin
        if (w_hwe) r_hist[w_haddr] <= w_hwd;
        r_hrd <= r_hist[w_haddr];
    end

    // Sequencer state
    t_state r_st, n_st;
    logic [BIN_W:0]   r_cnt, n_cnt;    // clear sweep counter
    logic [11:0]      r_i, n_i;        // scanned bin
    logic [4:0]       r_j, n_j;        // window offset 0..2W
    logic [15:0]      r_c, n_c;        // center count
    logic             r_pk, n_pk;
    logic             r_have, n_have;
    logic [11:0]      r_last, n_last;
    logic [15:0]      r_acc, n_acc;
    logic [PEAK_W:0]  r_pcnt, n_pcnt;
    logic [PEAK_W:0]  r_p, n_p;
    logic [15:0]      r_max, n_max;
    logic [5:0]       r_nt, n_nt;
    logic [15:0]      r_used, n_used;
    logic [24:0]      r_prod, n_prod;
    logic [BIN_W-1:0] r_bin, n_bin;
    logic [21:0]      r_num;
    t_out_item        r_out, n_out;
    logic             r_ov, n_ov;
    t_div_req         w_dreq;
    t_div_rsp         w_drsp;

    eht_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_dreq),
        .o_rsp   (w_drsp)
    );

    // Peak lists
    logic [BIN_W-1:0] r_pbin [MAX_PEAKS];
    logic [15:0]      r_psum [MAX_PEAKS];
    logic [BIN_W-1:0] r_pbin_rd;
    logic [15:0]      r_psum_rd;
    logic             w_pwe;
    logic [PEAK_W-1:0] w_paddr;
    always_ff @(posedge i_clk) begin
        if (w_pwe) begin
            r_pbin[w_paddr] <= r_i[BIN_W-1:0];
            r_psum[w_paddr] <= r_acc;
        end
        r_pbin_rd <= r_pbin[w_paddr];
        r_psum_rd <= r_psum[w_paddr];
    end

    // Binning numerator 2e + bw(2z+1), denominator 2bw
    logic signed [22:0] w_n;
    logic [20:0] w_bz;
    assign w_bz = 21'(w_bw) * 21'({r_zero_bin, 1'b1});
    assign w_n  = 23'(signed'({in_ch.data.elevation, 1'b0})) + signed'({2'b0, w_bz});

    always_ff @(posedge i_clk) begin
        if (in_ch.valid && in_ch.ready) r_num <= w_n[22] ? '0 : w_n[21:0];
    end
    logic r_neg;
    always_ff @(posedge i_clk) begin
        if (in_ch.valid && in_ch.ready) r_neg <= w_n[22];
    end

    assign w_dreq.start = (r_st == ST_DIV) && (r_cnt == '0);
    assign w_dreq.num   = r_num;
    assign w_dreq.den   = {w_bw, 1'b0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= ST_CLEAR;
            r_cnt  <= '0;
            r_ov   <= 1'b0;
            r_have <= 1'b0;
            r_pcnt <= '0;
            r_nt   <= '0;
        end else begin
            r_st   <= n_st;
            r_cnt  <= n_cnt;
            r_ov   <= n_ov;
            r_have <= n_have;
            r_pcnt <= n_pcnt;
            r_nt   <= n_nt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i <= n_i; r_j <= n_j; r_c <= n_c; r_pk <= n_pk; r_last <= n_last;
        r_acc <= n_acc; r_p <= n_p; r_max <= n_max;
        r_used <= n_used; r_prod <= n_prod; r_bin <= n_bin; r_out <= n_out;
    end

    logic [11:0] w_lo, w_off;
    logic [17:0] w_sacc;
    logic [12:0] w_hi;
    logic [16:0] w_used;
    logic signed [22:0] w_el;
    logic [21:0] w_q;
    assign w_lo   = r_i - 12'(w_w);
    assign w_off  = w_lo + 12'(r_j);
    assign w_sacc = 18'(r_acc) + 18'(r_hrd);
    assign w_hi   = 13'(w_nb) - 13'(w_w);
    assign w_used = 17'(r_used) + 17'(r_psum_rd);
    assign w_q    = r_neg ? 22'd0 : w_drsp.quo;
    assign w_el   = signed'(r_prod[22:0]);

    assign in_ch.ready = (r_st == ST_IDLE);
    assign out_ch.valid = r_ov;
    assign out_ch.data  = r_out;

    always_comb begin
        n_st = r_st; n_cnt = r_cnt; n_i = r_i; n_j = r_j; n_c = r_c; n_pk = r_pk;
        n_have = r_have; n_last = r_last; n_acc = r_acc; n_pcnt = r_pcnt; n_p = r_p;
        n_max = r_max; n_nt = r_nt; n_used = r_used; n_prod = r_prod; n_bin = r_bin;
        n_out = r_out; n_ov = r_ov;
        w_haddr = r_bin; w_hwe = 1'b0; w_hwd = '0;
        w_pwe = 1'b0; w_paddr = r_p[PEAK_W-1:0];
        if (out_ch.valid && out_ch.ready) n_ov = 1'b0;
        unique case (r_st)
            ST_IDLE: begin
                if (in_ch.valid) begin
                    if (in_ch.data.op == OP_LOAD) begin
                        n_st = ST_DIV; n_cnt = '0;
                    end else begin
                        n_st = ST_SCAN_SET; n_i = 12'(w_w);
                        n_have = 1'b0; n_pcnt = '0; n_max = '0;
                    end
                end
            end
            ST_CLEAR: begin
                w_haddr = r_cnt[BIN_W-1:0]; w_hwe = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == (BIN_W+1)'(NUM_BINS-1)) begin
                    n_st = ST_IDLE; n_cnt = '0;
                end
            end
            ST_DIV: begin
                n_cnt = (BIN_W+1)'(1);
                if (w_drsp.done) begin
                    n_cnt = '0;
                    n_bin = (w_q > 22'(w_nb - 11'd1)) ? BIN_W'(w_nb - 11'd1)
                                                      : w_q[BIN_W-1:0];
                    n_st = ST_INC_RD;
                end
            end
            ST_INC_RD: n_st = ST_INC_WR;
            ST_INC_WR: begin
                w_hwe = 1'b1;
                w_hwd = (r_hrd == 16'hFFFF) ? r_hrd : r_hrd + 16'd1;
                n_st = ST_IDLE;
            end
            // Scan: read center then window bins one a cycle
            ST_SCAN_SET: begin
                if ({1'b0, r_i} >= w_hi || w_hi[12]) begin
                    n_st = ST_FILT_RD; n_p = '0; n_nt = '0; n_used = '0;
                    n_max = (r_max > 16'(r_bpc)) ? 16'(r_bpc) : r_max;
                end else begin
                    w_haddr = r_i[BIN_W-1:0];
                    n_j = '0; n_st = ST_SCAN_RD; n_pk = 1'b1;
                end
            end
            ST_SCAN_RD: begin
                n_c = r_hrd; n_pk = (r_hrd != '0);
                w_haddr = w_lo[BIN_W-1:0];
                n_st = ST_SCAN_CMP;
            end
            ST_SCAN_CMP: begin
                if (w_off != r_i) begin
                    if ((w_off == r_i - 12'd1) || (w_off == r_i + 12'd1)) begin
                        if (r_c < r_hrd) n_pk = 1'b0;
                    end else if (r_c <= r_hrd) n_pk = 1'b0;
                end
                n_j = r_j + 5'd1;
                w_haddr = BIN_W'(w_off + 12'd1);
                if (r_j == {w_w, 1'b0}) begin
                    n_st = ST_SCAN_SET; n_i = r_i + 12'd1;
                    if (n_pk && !(r_have && (r_i - r_last) <= 12'd3)) begin
                        n_have = 1'b1; n_last = r_i;
                        if (r_pcnt < (PEAK_W+1)'(MAX_PEAKS)) begin
                            n_st = ST_SUM_RD; n_j = '0; n_acc = '0;
                            n_i = r_i;
                        end
                    end
                    if (n_st == ST_SCAN_SET) w_haddr = BIN_W'(r_i + 12'd1);
                end
            end
            ST_SUM_RD: begin
                w_haddr = w_lo[BIN_W-1:0]; n_st = ST_SUM_ACC;
            end
            ST_SUM_ACC: begin
                n_acc = w_sacc[17:16] != 2'b0 ? 16'hFFFF : w_sacc[15:0];
                n_j = r_j + 5'd1;
                w_haddr = BIN_W'(w_off + 12'd1);
                if (r_j == {w_w, 1'b0}) n_st = ST_SUM_END;
            end
            ST_SUM_END: begin
                w_pwe = 1'b1; w_paddr = r_pcnt[PEAK_W-1:0];
                n_pcnt = r_pcnt + 1'b1;
                if (r_acc > r_max) n_max = r_acc;
                n_i = r_i + 12'd1; n_st = ST_SCAN_SET;
            end
            // Filter stored peaks one by one
            ST_FILT_RD: begin
                if (r_p == r_pcnt) n_st = ST_SUMMARY;
                else n_st = ST_FILT_MUL;
            end
            ST_FILT_MUL: begin
                n_prod = 25'(r_min_frac) * 25'(r_max);
                n_st = ST_FILT_CHK;
            end
            ST_FILT_CHK: begin
                n_p = r_p + 1'b1; n_st = ST_FILT_RD;
                if (!((r_check[0] && r_psum_rd < r_min_beams) ||
                      (r_check[1] && {r_psum_rd, 8'd0} < r_prod[23:0]) ||
                      r_nt >= 6'(MAX_TILTS))) begin
                    n_prod = 25'(signed'(13'({1'b0, r_pbin_rd}) - 13'({3'b0, r_zero_bin})))
                           * 25'(w_bw);
                    n_st = ST_ELEV_MUL; n_p = r_p;
                end
            end
            ST_ELEV_MUL: begin
                if (!r_ov) begin
                    n_nt = r_nt + 6'd1;
                    n_used = w_used[16] ? 16'hFFFF : w_used[15:0];
                    n_out.kind = KIND_TILT;
                    n_out.tilt_elevation = (w_el > 23'sd131071) ? 18'h1FFFF :
                        (w_el < -23'sd131072) ? 18'h20000 : w_el[17:0];
                    n_out.tilt_beams = r_psum_rd;
                    n_out.tilt_count = r_nt + 6'd1;
                    n_out.beams_used = '0;
                    n_out.last = 1'b0;
                    n_ov = 1'b1;
                    n_p = r_p + 1'b1; n_st = ST_FILT_RD;
                end
            end
            ST_SUMMARY: begin
                if (!r_ov) begin
                    n_out.kind = KIND_SUMMARY;
                    n_out.tilt_elevation = '0;
                    n_out.tilt_beams = '0;
                    n_out.tilt_count = r_nt;
                    n_out.beams_used = r_used;
                    n_out.last = 1'b1;
                    n_ov = 1'b1;
                    n_st = ST_CLEAR; n_cnt = '0;
                end
            end
            default: n_st = ST_IDLE;
        endcase
        if (r_st == ST_FILT_RD) w_paddr = r_p[PEAK_W-1:0];
    end

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_ch.ready |-> !(r_st == ST_CLEAR)) else $error("ready during clear");
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nt <= 6'(MAX_TILTS)) else $error("tilt count above limit");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_ch.valid && !out_ch.ready) |=> $stable(r_out)) else $error("result changed");
    a_peaks_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pcnt <= (PEAK_W+1)'(MAX_PEAKS)) else $error("peak count above limit");
endmodule
